// ===== rtl/tst_pkg.sv =====
// ----------------------------------------------------------------------------
// tst_pkg
// Shared widths, operation codes and slot entry layout for the timer slot table.
// ----------------------------------------------------------------------------
package tst_pkg;

    localparam int KIND_W        = 2;
    localparam int TIME_W        = 48;
    localparam int MS_W          = 24;
    localparam int TAG_W         = 16;
    localparam int ID_W          = 16;
    localparam int RSLOT_W       = 8;
    localparam int PROD_W        = 34;
    localparam int US_PER_MS     = 1000;
    localparam int SLOTS_DEFAULT = 128;

    localparam logic [KIND_W-1:0] KIND_SCHEDULE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEXT     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RUN      = 2'd3;

    typedef struct packed {
        logic              active;
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
    } tst_entry_t;

    localparam int ENTRY_W = $bits(tst_entry_t);

endpackage

// ===== rtl/tst_ram.sv =====
// ----------------------------------------------------------------------------
// tst_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tst_ram #(
    parameter int WIDTH = tst_pkg::ENTRY_W,
    parameter int DEPTH = tst_pkg::SLOTS_DEFAULT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tst_deadline.sv =====
// ----------------------------------------------------------------------------
// tst_deadline
// Deadline arithmetic: registered ms to us product, then saturating add to now.
// ----------------------------------------------------------------------------
module tst_deadline (
    input  logic                      clk,
    input  logic [tst_pkg::TIME_W-1:0] now_us,
    input  logic [tst_pkg::MS_W-1:0]   delay_ms,
    output logic [tst_pkg::TIME_W-1:0] deadline
);

    logic [tst_pkg::PROD_W-1:0]  prod_reg;
    logic [tst_pkg::PROD_W-1:0]  prod_next;
    logic [tst_pkg::TIME_W:0]    sum;

    assign prod_next = tst_pkg::PROD_W'(delay_ms) * tst_pkg::PROD_W'(tst_pkg::US_PER_MS);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign sum = {1'b0, now_us} + (tst_pkg::TIME_W + 1)'(prod_reg);

    // saturate past the top of the time range
    assign deadline = sum[tst_pkg::TIME_W] ? {tst_pkg::TIME_W{1'b1}}
                                           : sum[tst_pkg::TIME_W-1:0];

endmodule

// ===== rtl/timer_slot_table_core.sv =====
// ----------------------------------------------------------------------------
// timer_slot_table_core
// Timer slot table: schedule, delete, next query and run expired over one
// slot RAM scanned one entry per cycle through a single shared comparator.
// ----------------------------------------------------------------------------
// sequence: delete writes its slot in the delete state, then registers done;
//   a scan registers done on a schedule or run hit, else after the last slot
// throughput: one item at a time, busy high until done; set by the one RAM read
//   port feeding the comparator one slot per cycle
// reset: busy stays high after reset while the clear state frees every slot
// the receiver cannot stall: each result comes with a one-cycle done strobe
module timer_slot_table_core #(
    parameter int SLOTS = tst_pkg::SLOTS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tst_pkg::KIND_W-1:0]  kind,
    input  logic [tst_pkg::TIME_W-1:0]  now_us,
    input  logic [tst_pkg::MS_W-1:0]    delay_ms,
    input  logic [tst_pkg::TAG_W-1:0]   tag,
    input  logic [tst_pkg::ID_W-1:0]    slot_id,
    output logic                        busy,
    output logic                        done,
    output logic [tst_pkg::RSLOT_W-1:0] result_slot,
    output logic                        found,
    output logic [tst_pkg::TIME_W-1:0]  deadline_out,
    output logic [tst_pkg::TAG_W-1:0]   tag_out,
    output logic                        bad_id
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOTS - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DEL   = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            addr_reg, addr_next;
    logic                        pvalid_reg, pvalid_next;
    logic [IDX_W-1:0]            pidx_reg, pidx_next;
    logic                        have_reg, have_next;
    logic                        done_reg, done_next;

    logic [tst_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [tst_pkg::TIME_W-1:0]  now_reg, now_next;
    logic [tst_pkg::MS_W-1:0]    ms_reg, ms_next;
    logic [tst_pkg::TAG_W-1:0]   tag_reg, tag_next;
    logic [tst_pkg::ID_W-1:0]    id_reg, id_next;
    logic [tst_pkg::TIME_W-1:0]  best_reg, best_next;

    logic [tst_pkg::RSLOT_W-1:0] rslot_reg, rslot_next;
    logic                        found_reg, found_next;
    logic [tst_pkg::TIME_W-1:0]  dl_reg, dl_next;
    logic [tst_pkg::TAG_W-1:0]   rtag_reg, rtag_next;
    logic                        bad_reg, bad_next;

    logic                        rd_en;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    tst_pkg::tst_entry_t         wr_entry;
    tst_pkg::tst_entry_t         rd_entry;
    logic [tst_pkg::ENTRY_W-1:0] rd_word;

    logic [tst_pkg::TIME_W-1:0]  new_deadline;
    logic [tst_pkg::TIME_W-1:0]  cmp_b;
    logic                        cmp_le;
    logic                        hit;
    logic                        id_bad;
    logic [31:0]                 slot_plus_one;

    tst_ram #(
        .WIDTH (tst_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (addr_reg[IDX_W-1:0]),
        .rd_data (rd_word)
    );

    tst_deadline u_deadline (
        .clk      (clk),
        .now_us   (now_reg),
        .delay_ms (ms_reg),
        .deadline (new_deadline)
    );

    assign rd_entry = rd_word;

    // shared comparator: against now for run, against running minimum for next
    assign cmp_b  = (kind_reg == tst_pkg::KIND_RUN) ? now_reg : best_reg;
    assign cmp_le = (rd_entry.deadline <= cmp_b);

    assign id_bad        = ({1'b0, id_reg} > (tst_pkg::ID_W + 1)'(SLOTS));
    assign slot_plus_one = 32'(pidx_reg) + 32'd1;

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        pvalid_next = pvalid_reg;
        pidx_next   = pidx_reg;
        have_next   = have_reg;
        done_next   = 1'b0;
        kind_next   = kind_reg;
        now_next    = now_reg;
        ms_next     = ms_reg;
        tag_next    = tag_reg;
        id_next     = id_reg;
        best_next   = best_reg;
        rslot_next  = rslot_reg;
        found_next  = found_reg;
        dl_next     = dl_reg;
        rtag_next   = rtag_reg;
        bad_next    = bad_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = pidx_reg;
        wr_entry    = '0;
        hit         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_reg[IDX_W-1:0];
                if (addr_reg == CNT_LAST)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next   = kind;
                    now_next    = now_us;
                    ms_next     = delay_ms;
                    tag_next    = tag;
                    id_next     = slot_id;
                    addr_next   = '0;
                    pvalid_next = 1'b0;
                    have_next   = 1'b0;
                    state_next  = (kind == tst_pkg::KIND_DELETE) ? ST_DEL : ST_SCAN;
                end
            end

            ST_DEL:
            begin
                wr_addr    = IDX_W'(id_reg - 1'b1);
                wr_en      = (id_reg != '0) && !id_bad;
                rslot_next = '0;
                found_next = 1'b0;
                dl_next    = '0;
                rtag_next  = '0;
                bad_next   = id_bad;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                if (addr_reg != CNT_END)
                begin
                    rd_en       = 1'b1;
                    addr_next   = addr_reg + 1'b1;
                    pvalid_next = 1'b1;
                    pidx_next   = addr_reg[IDX_W-1:0];
                end
                else
                begin
                    pvalid_next = 1'b0;
                end

                if (pvalid_reg)
                begin
                    case (kind_reg)
                        tst_pkg::KIND_SCHEDULE: hit = !rd_entry.active;
                        tst_pkg::KIND_RUN:      hit = rd_entry.active && cmp_le;
                        default:                hit = 1'b0;
                    endcase
                    if ((kind_reg == tst_pkg::KIND_NEXT) && rd_entry.active
                        && (!have_reg || cmp_le))
                    begin
                        best_next = rd_entry.deadline;
                        have_next = 1'b1;
                    end
                end

                if (hit)
                begin
                    wr_en      = 1'b1;
                    rslot_next = slot_plus_one[tst_pkg::RSLOT_W-1:0];
                    found_next = 1'b1;
                    bad_next   = 1'b0;
                    if (kind_reg == tst_pkg::KIND_SCHEDULE)
                    begin
                        wr_entry.active   = 1'b1;
                        wr_entry.deadline = new_deadline;
                        wr_entry.tag      = tag_reg;
                        dl_next           = '0;
                        rtag_next         = '0;
                    end
                    else
                    begin
                        wr_entry.active   = 1'b0;
                        wr_entry.deadline = rd_entry.deadline;
                        wr_entry.tag      = rd_entry.tag;
                        dl_next           = rd_entry.deadline;
                        rtag_next         = rd_entry.tag;
                    end
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!pvalid_reg && (addr_reg == CNT_END))
                begin
                    rslot_next = '0;
                    rtag_next  = '0;
                    bad_next   = 1'b0;
                    if (kind_reg == tst_pkg::KIND_NEXT)
                    begin
                        found_next = have_reg;
                        dl_next    = have_reg ? best_reg : '0;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        dl_next    = '0;
                    end
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            addr_reg   <= '0;
            pvalid_reg <= 1'b0;
            have_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            pvalid_reg <= pvalid_next;
            have_reg   <= have_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg  <= pidx_next;
        kind_reg  <= kind_next;
        now_reg   <= now_next;
        ms_reg    <= ms_next;
        tag_reg   <= tag_next;
        id_reg    <= id_next;
        best_reg  <= best_next;
        rslot_reg <= rslot_next;
        found_reg <= found_next;
        dl_reg    <= dl_next;
        rtag_reg  <= rtag_next;
        bad_reg   <= bad_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign result_slot  = rslot_reg;
    assign found        = found_reg;
    assign deadline_out = dl_reg;
    assign tag_out      = rtag_reg;
    assign bad_id       = bad_reg;

endmodule

// ===== rtl/tst_checker.sv =====
// ----------------------------------------------------------------------------
// tst_checker
// Port-level checks for the timer slot table, bound to the top level.
// ----------------------------------------------------------------------------
module tst_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [tst_pkg::RSLOT_W-1:0] result_slot,
    input logic                        found,
    input logic [tst_pkg::TIME_W-1:0]  deadline_out,
    input logic [tst_pkg::TAG_W-1:0]   tag_out,
    input logic                        bad_id
);

    // an accepted transfer makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    // a result strobe lasts one cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // a result is only given once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // nothing found means empty result fields
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (result_slot == '0 && deadline_out == '0 && tag_out == '0))
        else $error("result fields set without found");

    // a bad id only comes with a plain delete result
    a_bad_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_id) |-> !found)
        else $error("bad id together with found");

endmodule

bind timer_slot_table_core tst_checker u_tst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .result_slot  (result_slot),
    .found        (found),
    .deadline_out (deadline_out),
    .tag_out      (tag_out),
    .bad_id       (bad_id)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for timer_slot_table_core. Commands are driven through
// the start/busy handshake with random gaps. A scoreboard keeps its own copy of
// the slot table, predicts one result per accepted transfer and compares every
// done strobe field by field. Directed corner cases run first. Random episodes
// follow: mixed traffic, run sweeps, delete bursts, table fills and raw noise.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = tst_pkg::SLOTS_DEFAULT;
    localparam int ITEMS = 1350;
    localparam int SUM_W = tst_pkg::TIME_W + 1;
    localparam logic [tst_pkg::TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [tst_pkg::KIND_W-1:0] kind;
        logic [tst_pkg::TIME_W-1:0] now_us;
        logic [tst_pkg::MS_W-1:0]   delay_ms;
        logic [tst_pkg::TAG_W-1:0]  tag;
        logic [tst_pkg::ID_W-1:0]   slot_id;
    } timer_op_t;

    typedef struct packed {
        logic [tst_pkg::RSLOT_W-1:0] result_slot;
        logic                        found;
        logic [tst_pkg::TIME_W-1:0]  deadline_out;
        logic [tst_pkg::TAG_W-1:0]   tag_out;
        logic                        bad_id;
    } timer_result_t;

    class slot_table_scoreboard;
        bit                         active [SLOTS];
        logic [tst_pkg::TIME_W-1:0] deadline [SLOTS];
        logic [tst_pkg::TAG_W-1:0]  stored_tag [SLOTS];
        timer_result_t              outstanding [$];
        int failures = 0;
        int checked = 0;
        int n_sched = 0, n_full = 0, n_del = 0, n_bad = 0;
        int n_next = 0, n_run = 0, n_expired = 0;

        function timer_result_t note_transfer(timer_op_t op);
            timer_result_t r;
            logic [SUM_W-1:0] sum;
            logic [tst_pkg::TIME_W-1:0] best;
            logic have;
            int i;
            r = '0;
            have = 1'b0;
            best = '0;
            case (op.kind)
                tst_pkg::KIND_SCHEDULE:
                begin
                    n_sched++;
                    for (i = 0; i < SLOTS && !have; i++)
                    begin
                        if (!active[i])
                        begin
                            have = 1'b1;
                            active[i] = 1'b1;
                            sum = {1'b0, op.now_us}
                                + SUM_W'(op.delay_ms) * SUM_W'(tst_pkg::US_PER_MS);
                            deadline[i] = sum[tst_pkg::TIME_W] ? TIME_MAX
                                                               : sum[tst_pkg::TIME_W-1:0];
                            stored_tag[i] = op.tag;
                            r.result_slot = tst_pkg::RSLOT_W'(i + 1);
                            r.found = 1'b1;
                        end
                    end
                    if (!have)
                        n_full++;
                end
                tst_pkg::KIND_DELETE:
                begin
                    n_del++;
                    if (op.slot_id != '0)
                    begin
                        if (op.slot_id <= SLOTS)
                            active[op.slot_id - 1] = 1'b0;
                        else
                        begin
                            r.bad_id = 1'b1;
                            n_bad++;
                        end
                    end
                end
                tst_pkg::KIND_NEXT:
                begin
                    n_next++;
                    for (i = SLOTS - 1; i >= 0; i--)
                    begin
                        if (active[i] && (!have || deadline[i] < best))
                        begin
                            best = deadline[i];
                            have = 1'b1;
                        end
                    end
                    r.found = have;
                    r.deadline_out = have ? best : '0;
                end
                default:
                begin
                    n_run++;
                    for (i = 0; i < SLOTS && !have; i++)
                    begin
                        if (active[i] && deadline[i] <= op.now_us)
                        begin
                            have = 1'b1;
                            active[i] = 1'b0;
                            r.result_slot = tst_pkg::RSLOT_W'(i + 1);
                            r.found = 1'b1;
                            r.deadline_out = deadline[i];
                            r.tag_out = stored_tag[i];
                            n_expired++;
                        end
                    end
                end
            endcase
            outstanding.push_back(r);
            return r;
        endfunction

        function void check_result(timer_result_t got);
            timer_result_t want;
            logic wrong;
            if (outstanding.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with no transfer outstanding: slot %0d found %0b",
                             $realtime, got.result_slot, got.found);
                return;
            end
            want = outstanding.pop_front();
            checked++;
            wrong = (got.result_slot !== want.result_slot) || (got.found !== want.found)
                 || (got.deadline_out !== want.deadline_out)
                 || (got.tag_out !== want.tag_out) || (got.bad_id !== want.bad_id);
            if (wrong)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("%0t: result %0d mismatch", $realtime, checked);
                    $display("  expected slot %0d found %0b deadline %h tag %h bad_id %0b",
                             want.result_slot, want.found, want.deadline_out,
                             want.tag_out, want.bad_id);
                    $display("  actual   slot %0d found %0b deadline %h tag %h bad_id %0b",
                             got.result_slot, got.found, got.deadline_out,
                             got.tag_out, got.bad_id);
                end
            end
        endfunction

        function int pick_active();
            int ids [$];
            for (int i = 0; i < SLOTS; i++)
                if (active[i])
                    ids.push_back(i + 1);
            if (ids.size() == 0)
                return 0;
            return ids[$urandom_range(0, ids.size() - 1)];
        endfunction

        function int pending();
            return outstanding.size();
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic [tst_pkg::KIND_W-1:0]   kind = '0;
    logic [tst_pkg::TIME_W-1:0]   now_us = '0;
    logic [tst_pkg::MS_W-1:0]     delay_ms = '0;
    logic [tst_pkg::TAG_W-1:0]    tag = '0;
    logic [tst_pkg::ID_W-1:0]     slot_id = '0;
    logic                         busy;
    logic                         done;
    logic [tst_pkg::RSLOT_W-1:0]  result_slot;
    logic                         found;
    logic [tst_pkg::TIME_W-1:0]   deadline_out;
    logic [tst_pkg::TAG_W-1:0]    tag_out;
    logic                         bad_id;

    slot_table_scoreboard board = new();
    timer_result_t                last_want;
    logic [tst_pkg::TIME_W-1:0]   cur_us;
    int                           items = 0;
    bit                           quiet = 1'b0;

    timer_slot_table_core #(.SLOTS(SLOTS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .kind(kind),
        .now_us(now_us),
        .delay_ms(delay_ms),
        .tag(tag),
        .slot_id(slot_id),
        .busy(busy),
        .done(done),
        .result_slot(result_slot),
        .found(found),
        .deadline_out(deadline_out),
        .tag_out(tag_out),
        .bad_id(bad_id)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            board.check_result({result_slot, found, deadline_out, tag_out, bad_id});
    end

    function automatic timer_op_t rand_op();
        timer_op_t op;
        op.kind = tst_pkg::KIND_W'($urandom_range(0, 3));
        op.now_us = tst_pkg::TIME_W'({$urandom, $urandom});
        op.delay_ms = tst_pkg::MS_W'($urandom);
        op.tag = tst_pkg::TAG_W'($urandom);
        op.slot_id = tst_pkg::ID_W'($urandom);
        return op;
    endfunction

    task automatic issue(input timer_op_t op);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        kind <= op.kind;
        now_us <= op.now_us;
        delay_ms <= op.delay_ms;
        tag <= op.tag;
        slot_id <= op.slot_id;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        last_want = board.note_transfer(op);
        items++;
    endtask

    task automatic sched(input logic [tst_pkg::TIME_W-1:0] at,
                         input logic [tst_pkg::MS_W-1:0] ms,
                         input logic [tst_pkg::TAG_W-1:0] tg);
        timer_op_t op;
        op = rand_op();
        op.kind = tst_pkg::KIND_SCHEDULE;
        op.now_us = at;
        op.delay_ms = ms;
        op.tag = tg;
        issue(op);
    endtask

    task automatic del(input int id);
        timer_op_t op;
        op = rand_op();
        op.kind = tst_pkg::KIND_DELETE;
        op.slot_id = tst_pkg::ID_W'(id);
        issue(op);
    endtask

    task automatic next_q();
        timer_op_t op;
        op = rand_op();
        op.kind = tst_pkg::KIND_NEXT;
        issue(op);
    endtask

    task automatic run_at(input logic [tst_pkg::TIME_W-1:0] at);
        timer_op_t op;
        op = rand_op();
        op.kind = tst_pkg::KIND_RUN;
        op.now_us = at;
        issue(op);
    endtask

    task automatic run_sweep(input int cap);
        int n;
        n = 0;
        do
        begin
            run_at(cur_us);
            n++;
        end
        while (last_want.found && n < cap);
    endtask

    task automatic del_pick();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            del(board.pick_active());
        else if (sel == 7)
            del($urandom_range(1, SLOTS));
        else if (sel == 8)
            del(0);
        else
            del($urandom_range(SLOTS + 1, 65535));
    endtask

    task automatic fill_and_drain();
        do
            sched(cur_us, tst_pkg::MS_W'($urandom_range(100, 3000)),
                  tst_pkg::TAG_W'($urandom));
        while (last_want.found);
        sched(cur_us, tst_pkg::MS_W'($urandom), tst_pkg::TAG_W'($urandom));
        next_q();
        repeat ($urandom_range(1, 4)) del_pick();
        repeat (3) sched(cur_us, tst_pkg::MS_W'($urandom_range(0, 3000)),
                         tst_pkg::TAG_W'($urandom));
        next_q();
        cur_us = cur_us + 4_000_000;
        run_sweep(SLOTS + 1);
    endtask

    initial
    begin
        bit filled_a;
        bit filled_b;
        filled_a = 1'b0;
        filled_b = 1'b0;
        cur_us = tst_pkg::TIME_W'({$urandom, $urandom} >> 17);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        next_q();
        run_at(TIME_MAX);
        del(0);
        del(SLOTS + 1);
        del(16'hFFFF);
        del(5);
        sched('0, '0, 16'hFFFF);
        sched(TIME_MAX, 24'hFFFFFF, '0);
        sched(1000, 1, 16'h1234);
        sched('0, 2, 16'hABCD);
        next_q();
        del(1);
        next_q();
        run_at(1999);
        run_at(2000);
        run_at(2000);
        run_at(TIME_MAX - 1);
        run_at(TIME_MAX);
        run_at(TIME_MAX);
        del(SLOTS);
        next_q();

        while (items < ITEMS)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            if ((!filled_a && items >= 400) || (!filled_b && items >= 900))
            begin
                fill_and_drain();
                if (filled_a)
                    filled_b = 1'b1;
                filled_a = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                        repeat ($urandom_range(10, 30))
                        begin
                            case ($urandom_range(0, 9))
                                0, 1, 2, 3:
                                    sched(cur_us,
                                          ($urandom_range(0, 3) == 0)
                                              ? tst_pkg::MS_W'($urandom_range(0, 5000))
                                              : tst_pkg::MS_W'($urandom_range(0, 40)),
                                          tst_pkg::TAG_W'($urandom));
                                4, 5:
                                    del_pick();
                                6:
                                    next_q();
                                7, 8:
                                begin
                                    cur_us = cur_us + $urandom_range(0, 5000);
                                    run_at(cur_us);
                                end
                                default:
                                begin
                                    cur_us = cur_us + $urandom_range(0, 20000);
                                    run_sweep(8);
                                end
                            endcase
                        end
                    6, 7:
                    begin
                        cur_us = cur_us + $urandom_range(0, 60000);
                        run_sweep(SLOTS + 1);
                    end
                    8:
                        repeat ($urandom_range(5, 15)) del_pick();
                    default:
                        repeat ($urandom_range(3, 8)) issue(rand_op());
                endcase
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        $display("%0d transfers checked: %0d schedules (%0d on a full table), %0d deletes (%0d bad ids)",
                 board.checked, board.n_sched, board.n_full, board.n_del, board.n_bad);
        $display("%0d next queries, %0d runs expiring %0d timers, %0d failures",
                 board.n_next, board.n_run, board.n_expired, board.failures);
        if (board.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", board.pending());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
